// ===== design/i2cram_pkg.sv =====
package i2cram_pkg;

  // Bus sequencer phases, one-hot.
  typedef enum logic [15:0] {
    PH_IDLE      = 16'b0000_0000_0000_0001,
    PH_START_A   = 16'b0000_0000_0000_0010,
    PH_START_B   = 16'b0000_0000_0000_0100,
    PH_TX_LOW    = 16'b0000_0000_0000_1000,
    PH_TX_HIGH   = 16'b0000_0000_0001_0000,
    PH_ACK_LOW   = 16'b0000_0000_0010_0000,
    PH_ACK_HIGH  = 16'b0000_0000_0100_0000,
    PH_ACK_POLL  = 16'b0000_0000_1000_0000,
    PH_RS_A      = 16'b0000_0001_0000_0000,
    PH_RX_LOW    = 16'b0000_0010_0000_0000,
    PH_RX_HIGH   = 16'b0000_0100_0000_0000,
    PH_NACK_LOW  = 16'b0000_1000_0000_0000,
    PH_NACK_HIGH = 16'b0001_0000_0000_0000,
    PH_STOP_A    = 16'b0010_0000_0000_0000,
    PH_STOP_B    = 16'b0100_0000_0000_0000,
    PH_STOP_C    = 16'b1000_0000_0000_0000
  } phase_t;

  // Configuration register indexes.
  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 8;
  localparam logic [CFG_AW-1:0] CFG_DEV_ADDR    = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_ACK_TIMEOUT = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_PHASE_TICKS = 2'd2;

  // Register reset values.
  localparam logic [6:0] DEV_ADDR_RST    = 7'd40;
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
  localparam logic [7:0] PHASE_TICKS_RST = 8'd8;

  // Byte step within a transaction.
  localparam logic [1:0] STEP_ADDR = 2'd0;
  localparam logic [1:0] STEP_REG  = 2'd1;
  localparam logic [1:0] STEP_LAST = 2'd2;

  localparam int unsigned IN_DW  = 24;
  localparam int unsigned OUT_DW = 16;

endpackage

// ===== design/i2c_register_access_master.sv =====
// Channel | Dir | tdata fields (low bit up)                          | other
// --------+-----+----------------------------------------------------+----------------
// in_     | in  | start_req, reg_addr[7:0], wr_data[7:0], sda_in     | tuser = cmd
// out_    | out | scl, sda_out, sda_drive, busy_res, done_res,       | -
//         |     | rd_data[7:0], ack_error                            |
// cfg_    | in  | cfg_we, cfg_addr (register index), cfg_wdata       | write only
//
// Every input word is one bus tick. The sequencer state and the result register
// are updated in the cycle the word is accepted, so while the result side takes
// words one word per clock is taken, each giving exactly one result word in the next cycle.
// The result register parts the two sides: a new word is taken whenever the
// result register is empty or its word is taken in the same cycle.
// Reset (rst_n low, synchronous) returns the sequencer to idle, empties the
// result register and loads the register defaults (address 40, timeout 250,
// phase length 8).
module i2c_register_access_master (
  input  logic                          clk,
  input  logic                          rst_n,
  // start_req, reg_addr[7:0], wr_data[7:0], sda_in, zero fill
  input  logic [i2cram_pkg::IN_DW-1:0]  in_tdata,
  // cmd (0 register write, 1 register read)
  input  logic                          in_tuser,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // scl, sda_out, sda_drive, busy_res, done_res, rd_data[7:0], ack_error, zero fill
  output logic [i2cram_pkg::OUT_DW-1:0] out_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_we,
  input  logic [i2cram_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [i2cram_pkg::CFG_DW-1:0] cfg_wdata
);
  import i2cram_pkg::*;

  // Configuration registers.
  logic [6:0] dev_addr_r;
  logic [7:0] ack_timeout_r;
  logic [7:0] phase_ticks_r;

  // Sequencer state.
  phase_t     phase_r,      phase_nxt;
  logic [3:0] bit_cnt_r,    bit_cnt_nxt;
  logic [7:0] shift_r,      shift_nxt;
  logic [7:0] hold_cnt_r,   hold_cnt_nxt;
  logic [7:0] poll_cnt_r,   poll_cnt_nxt;
  logic       lat_cmd_r,    lat_cmd_nxt;
  logic [7:0] lat_reg_r,    lat_reg_nxt;
  logic [7:0] lat_data_r,   lat_data_nxt;
  logic [7:0] read_byte_r,  read_byte_nxt;
  logic       err_r,        err_nxt;
  logic [1:0] byte_step_r,  byte_step_nxt;

  // Result register.
  logic              out_valid_r;
  logic [OUT_DW-1:0] out_data_r, out_data_nxt;

  // Unpacked input fields.
  logic       start_req;
  logic [7:0] reg_addr;
  logic [7:0] wr_data;
  logic       sda_in;
  logic       in_acc;

  assign start_req = in_tdata[0];
  assign reg_addr  = in_tdata[8:1];
  assign wr_data   = in_tdata[16:9];
  assign sda_in    = in_tdata[17];

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // One tick of the bus sequencer.
  always_comb begin
    phase_t     ph;
    logic       scl_o, sda_o, drv_o, busy_o, done_o;
    logic [7:0] plen, tmo, poll_inc;
    logic [8:0] hold_inc;
    logic [3:0] bc_inc;
    logic [7:0] rx_shift;

    phase_nxt     = phase_r;
    bit_cnt_nxt   = bit_cnt_r;
    shift_nxt     = shift_r;
    hold_cnt_nxt  = hold_cnt_r;
    poll_cnt_nxt  = poll_cnt_r;
    lat_cmd_nxt   = lat_cmd_r;
    lat_reg_nxt   = lat_reg_r;
    lat_data_nxt  = lat_data_r;
    read_byte_nxt = read_byte_r;
    err_nxt       = err_r;
    byte_step_nxt = byte_step_r;
    done_o        = 1'b0;

    plen = (phase_ticks_r == 8'd0) ? 8'd1 : phase_ticks_r;
    tmo  = (ack_timeout_r == 8'd0) ? 8'd1 : ack_timeout_r;

    // A request while idle makes this tick the first tick of START.
    ph = phase_r;
    if (phase_r == PH_IDLE && start_req) begin
      lat_cmd_nxt   = in_tuser;
      lat_reg_nxt   = reg_addr;
      lat_data_nxt  = wr_data;
      err_nxt       = 1'b0;
      byte_step_nxt = STEP_ADDR;
      bit_cnt_nxt   = 4'd0;
      hold_cnt_nxt  = 8'd0;
      poll_cnt_nxt  = 8'd0;
      ph            = PH_START_A;
      phase_nxt     = PH_START_A;
    end

    // Line levels for the phase in force this tick.
    scl_o = 1'b1;
    sda_o = 1'b1;
    drv_o = 1'b1;
    case (ph)
      PH_START_B:   sda_o = 1'b0;
      PH_TX_LOW:    begin scl_o = 1'b0; sda_o = shift_r[7]; end
      PH_TX_HIGH:   sda_o = shift_r[7];
      PH_ACK_LOW:   begin scl_o = 1'b0; drv_o = 1'b0; end
      PH_ACK_HIGH:  drv_o = 1'b0;
      PH_ACK_POLL:  drv_o = 1'b0;
      PH_RS_A:      scl_o = 1'b0;
      PH_RX_LOW:    begin scl_o = 1'b0; drv_o = 1'b0; end
      PH_RX_HIGH:   drv_o = 1'b0;
      PH_NACK_LOW:  scl_o = 1'b0;
      PH_STOP_A:    begin scl_o = 1'b0; sda_o = 1'b0; end
      PH_STOP_B:    sda_o = 1'b0;
      default:      ;
    endcase
    busy_o = (ph != PH_IDLE);

    poll_inc = poll_cnt_nxt + 8'd1;
    hold_inc = {1'b0, hold_cnt_nxt} + 9'd1;
    bc_inc   = bit_cnt_nxt + 4'd1;
    rx_shift = {shift_r[6:0], sda_in};

    if (ph == PH_ACK_POLL) begin
      if (!sda_in) begin
        // Acknowledge seen: pick the next byte or phase.
        poll_cnt_nxt = 8'd0;
        if (byte_step_r == STEP_ADDR) begin
          shift_nxt     = lat_reg_r;
          byte_step_nxt = STEP_REG;
          bit_cnt_nxt   = 4'd0;
          phase_nxt     = PH_TX_LOW;
        end else if (byte_step_r == STEP_REG) begin
          byte_step_nxt = STEP_LAST;
          if (lat_cmd_r) begin
            phase_nxt = PH_RS_A;
          end else begin
            shift_nxt   = lat_data_r;
            bit_cnt_nxt = 4'd0;
            phase_nxt   = PH_TX_LOW;
          end
        end else if (lat_cmd_r) begin
          shift_nxt   = 8'd0;
          bit_cnt_nxt = 4'd0;
          phase_nxt   = PH_RX_LOW;
        end else begin
          phase_nxt = PH_STOP_A;
        end
      end else begin
        poll_cnt_nxt = poll_inc;
        if (poll_inc >= tmo) begin
          // Timed out: abort with STOP and flag it.
          poll_cnt_nxt = 8'd0;
          err_nxt      = 1'b1;
          phase_nxt    = PH_STOP_A;
        end
      end
      hold_cnt_nxt = 8'd0;
    end else if (ph != PH_IDLE) begin
      if (hold_inc < {1'b0, plen}) begin
        hold_cnt_nxt = hold_inc[7:0];
      end else begin
        hold_cnt_nxt = 8'd0;
        case (ph)
          PH_START_A: phase_nxt = PH_START_B;
          PH_START_B: begin
            shift_nxt   = {dev_addr_r, (byte_step_r != STEP_ADDR)};
            bit_cnt_nxt = 4'd0;
            phase_nxt   = PH_TX_LOW;
          end
          PH_TX_LOW:  phase_nxt = PH_TX_HIGH;
          PH_TX_HIGH: begin
            shift_nxt   = {shift_r[6:0], 1'b0};
            bit_cnt_nxt = bc_inc;
            phase_nxt   = (bc_inc >= 4'd8) ? PH_ACK_LOW : PH_TX_LOW;
          end
          PH_ACK_LOW:  phase_nxt = PH_ACK_HIGH;
          PH_ACK_HIGH: begin
            poll_cnt_nxt = 8'd0;
            phase_nxt    = PH_ACK_POLL;
          end
          PH_RS_A:    phase_nxt = PH_START_A;
          PH_RX_LOW:  phase_nxt = PH_RX_HIGH;
          PH_RX_HIGH: begin
            // Sample the read bit on the last tick of SCL high.
            shift_nxt   = rx_shift;
            bit_cnt_nxt = bc_inc;
            if (bc_inc >= 4'd8) begin
              read_byte_nxt = rx_shift;
              phase_nxt     = PH_NACK_LOW;
            end else begin
              phase_nxt = PH_RX_LOW;
            end
          end
          PH_NACK_LOW:  phase_nxt = PH_NACK_HIGH;
          PH_NACK_HIGH: phase_nxt = PH_STOP_A;
          PH_STOP_A:    phase_nxt = PH_STOP_B;
          PH_STOP_B:    phase_nxt = PH_STOP_C;
          PH_STOP_C: begin
            phase_nxt = PH_IDLE;
            done_o    = 1'b1;
          end
          default:      phase_nxt = PH_IDLE;
        endcase
      end
    end

    out_data_nxt = {2'b00, err_nxt, read_byte_nxt, done_o, busy_o, drv_o, sda_o, scl_o};
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r    <= DEV_ADDR_RST;
      ack_timeout_r <= ACK_TIMEOUT_RST;
      phase_ticks_r <= PHASE_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DEV_ADDR:    dev_addr_r    <= cfg_wdata[6:0];
        CFG_ACK_TIMEOUT: ack_timeout_r <= cfg_wdata;
        CFG_PHASE_TICKS: phase_ticks_r <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  // Sequencer state advances only on an accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_cnt_r   <= 4'd0;
      shift_r     <= 8'd0;
      hold_cnt_r  <= 8'd0;
      poll_cnt_r  <= 8'd0;
      lat_cmd_r   <= 1'b0;
      lat_reg_r   <= 8'd0;
      lat_data_r  <= 8'd0;
      read_byte_r <= 8'd0;
      err_r       <= 1'b0;
      byte_step_r <= STEP_ADDR;
    end else if (in_acc) begin
      phase_r     <= phase_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      shift_r     <= shift_nxt;
      hold_cnt_r  <= hold_cnt_nxt;
      poll_cnt_r  <= poll_cnt_nxt;
      lat_cmd_r   <= lat_cmd_nxt;
      lat_reg_r   <= lat_reg_nxt;
      lat_data_r  <= lat_data_nxt;
      read_byte_r <= read_byte_nxt;
      err_r       <= err_nxt;
      byte_step_r <= byte_step_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ===== verif/i2c_register_access_master_test.sv =====
// Testbench for the single-register I2C master.
//
// Every input word is one bus tick, and every tick gives back exactly one result
// word with the bus levels and status for that tick. A behavioral model of the
// bus sequencer runs in the testbench. It is stepped when an input word is
// accepted, and the result word it works out is queued. The monitor takes each
// accepted result word and compares it, field by field, with the oldest queued
// one.
//
// The sender chooses SDA for each tick from the model's current phase. It can
// act as a slave that acknowledges, withholds an acknowledge at a chosen byte,
// answers late, or presents a chosen byte on read bits. This is how the
// stimulus reaches complete writes, complete reads and every acknowledge abort.
module i2c_register_access_master_test;
  import i2cram_pkg::*;

  // Position of the withheld acknowledge that is never reached.
  localparam int ALL_ACK = 3;
  // Marks a typed-in expectation that is left to the model.
  localparam int UNCHECKED = -1;
  // Random ticks run under each random register setting.
  localparam int TICKS_PER_SETTING = 50;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // start_req, reg_addr[7:0], wr_data[7:0], sda_in, zero fill
  logic [IN_DW-1:0] in_tdata = '0;
  // cmd
  logic in_tuser = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // scl, sda_out, sda_drive, busy_res, done_res, rd_data[7:0], ack_error, zero fill
  logic [OUT_DW-1:0] out_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  i2c_register_access_master dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  typedef struct packed {
    logic       start_req;
    logic       cmd;
    logic [7:0] reg_addr;
    logic [7:0] wr_data;
    logic       sda_in;
  } tick_t;

  typedef struct {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy;
    logic       done;
    logic [7:0] rd_data;
    logic       ack_error;
  } bus_word_t;

  // One row of the directed part: either a few idle ticks or one transaction.
  // The slave withholds the acknowledge when the byte step reaches nack_at.
  // A rough row also answers acknowledges late and sends requests while busy.
  // exp_err and exp_rd are checked on every idle tick and on the done tick.
  typedef struct packed {
    bit         is_xfer;
    int         n_idle;
    logic [6:0] dev;
    logic [7:0] tmo;
    logic [7:0] plen;
    logic       cmd;
    logic [7:0] ra;
    logic [7:0] wd;
    int         nack_at;
    logic [7:0] slave_byte;
    bit         rough;
    int         exp_err;
    int         exp_rd;
  } plan_row_t;

  // Register settings as the block should hold them.
  logic [6:0] m_dev  = DEV_ADDR_RST;
  logic [7:0] m_tmo  = ACK_TIMEOUT_RST;
  logic [7:0] m_plen = PHASE_TICKS_RST;

  // Sequencer state of the model.
  phase_t     ph        = PH_IDLE;
  logic [3:0] bit_cnt   = '0;
  logic [7:0] shreg     = '0;
  logic [7:0] hold_cnt  = '0;
  logic [7:0] poll_cnt  = '0;
  logic       l_cmd     = 1'b0;
  logic [7:0] l_reg     = '0;
  logic [7:0] l_data    = '0;
  logic [7:0] rx_byte   = '0;
  logic       err_flag  = 1'b0;
  logic [1:0] byte_step = STEP_ADDR;

  bus_word_t bus_words_due[$];
  int mismatches = 0;
  int ticks_sent = 0;
  int xfers = 0;
  int reads = 0;
  int aborts = 0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  int out_stall = 0;

  // An acknowledge was seen; pick the next byte or the next phase.
  function automatic void ack_taken();
    poll_cnt = '0;
    if (byte_step == STEP_ADDR) begin
      shreg = l_reg;
      byte_step = STEP_REG;
      bit_cnt = '0;
      ph = PH_TX_LOW;
    end else if (byte_step == STEP_REG) begin
      if (!l_cmd) begin
        shreg = l_data;
        byte_step = STEP_LAST;
        bit_cnt = '0;
        ph = PH_TX_LOW;
      end else begin
        byte_step = STEP_LAST;
        ph = PH_RS_A;
      end
    end else begin
      if (!l_cmd) begin
        ph = PH_STOP_A;
      end else begin
        shreg = '0;
        bit_cnt = '0;
        ph = PH_RX_LOW;
      end
    end
  endfunction

  // A held phase has run out; returns 1 when the transaction ends.
  function automatic logic phase_over(logic sda);
    logic fin;
    fin = 1'b0;
    case (ph)
      PH_START_A: ph = PH_START_B;
      PH_START_B: begin
        shreg = {m_dev, byte_step != STEP_ADDR};
        bit_cnt = '0;
        ph = PH_TX_LOW;
      end
      PH_TX_LOW: ph = PH_TX_HIGH;
      PH_TX_HIGH: begin
        shreg = shreg << 1;
        bit_cnt = bit_cnt + 1'b1;
        ph = (bit_cnt >= 4'd8) ? PH_ACK_LOW : PH_TX_LOW;
      end
      PH_ACK_LOW: ph = PH_ACK_HIGH;
      PH_ACK_HIGH: begin
        poll_cnt = '0;
        ph = PH_ACK_POLL;
      end
      PH_RS_A: ph = PH_START_A;
      PH_RX_LOW: ph = PH_RX_HIGH;
      PH_RX_HIGH: begin
        shreg = {shreg[6:0], sda};
        bit_cnt = bit_cnt + 1'b1;
        if (bit_cnt >= 4'd8) begin
          rx_byte = shreg;
          ph = PH_NACK_LOW;
        end else begin
          ph = PH_RX_LOW;
        end
      end
      PH_NACK_LOW: ph = PH_NACK_HIGH;
      PH_NACK_HIGH: ph = PH_STOP_A;
      PH_STOP_A: ph = PH_STOP_B;
      PH_STOP_B: ph = PH_STOP_C;
      PH_STOP_C: begin
        ph = PH_IDLE;
        fin = 1'b1;
      end
      default: ph = PH_IDLE;
    endcase
    return fin;
  endfunction

  // Bus levels and status for one tick, then the state moves on.
  function automatic bus_word_t bus_tick(tick_t t);
    bus_word_t w;
    int unsigned plen;
    int unsigned tmo;
    logic fin;
    plen = (m_plen == 0) ? 1 : m_plen;
    tmo = (m_tmo == 0) ? 1 : m_tmo;
    fin = 1'b0;
    // A request taken while idle makes this tick the first one of START.
    if (ph == PH_IDLE && t.start_req) begin
      l_cmd = t.cmd;
      l_reg = t.reg_addr;
      l_data = t.wr_data;
      err_flag = 1'b0;
      byte_step = STEP_ADDR;
      bit_cnt = '0;
      hold_cnt = '0;
      poll_cnt = '0;
      ph = PH_START_A;
    end
    // Idle levels are all high; released SDA reports sda_out as 1.
    w.scl = 1'b1;
    w.sda_out = 1'b1;
    w.sda_drive = 1'b1;
    case (ph)
      PH_START_B: w.sda_out = 1'b0;
      PH_TX_LOW: begin
        w.scl = 1'b0;
        w.sda_out = shreg[7];
      end
      PH_TX_HIGH: w.sda_out = shreg[7];
      PH_ACK_LOW, PH_RX_LOW: begin
        w.scl = 1'b0;
        w.sda_drive = 1'b0;
      end
      PH_ACK_HIGH, PH_ACK_POLL, PH_RX_HIGH: w.sda_drive = 1'b0;
      PH_RS_A, PH_NACK_LOW: w.scl = 1'b0;
      PH_STOP_A: begin
        w.scl = 1'b0;
        w.sda_out = 1'b0;
      end
      PH_STOP_B: w.sda_out = 1'b0;
      default: ;
    endcase
    w.busy = (ph != PH_IDLE);
    if (ph == PH_ACK_POLL) begin
      if (!t.sda_in) begin
        ack_taken();
      end else begin
        poll_cnt = poll_cnt + 1'b1;
        // The slave stayed silent too long: send STOP and flag it.
        if (poll_cnt >= tmo) begin
          poll_cnt = '0;
          err_flag = 1'b1;
          ph = PH_STOP_A;
          aborts++;
        end
      end
      hold_cnt = '0;
    end else if (ph != PH_IDLE) begin
      if (int'(hold_cnt) + 1 < plen) begin
        hold_cnt = hold_cnt + 1'b1;
      end else begin
        hold_cnt = '0;
        fin = phase_over(t.sda_in);
      end
    end
    w.done = fin;
    w.rd_data = rx_byte;
    w.ack_error = err_flag;
    return w;
  endfunction

  // Gap length for either side: mostly none, sometimes short, rarely long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // SDA as a slave would present it on the coming tick.
  function automatic logic line_level(int nack_at, logic [7:0] slave_byte, bit jitter);
    if (ph == PH_ACK_POLL) begin
      if (byte_step == nack_at) return 1'b1;
      return jitter ? ($urandom_range(3) == 0) : 1'b0;
    end
    if (ph == PH_RX_LOW || ph == PH_RX_HIGH) return slave_byte[7 - bit_cnt];
    return 1'($urandom_range(1));
  endfunction

  // Offer one tick word, wait until it is taken, and queue its result word.
  // Typed-in expectations replace the model's value on idle and done ticks.
  task automatic send_tick(tick_t t, int exp_err, int exp_rd);
    bus_word_t w;
    int gap;
    if ($urandom_range(199) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {{(IN_DW - 18){1'b0}}, t.sda_in, t.wr_data, t.reg_addr, t.start_req};
    in_tuser <= t.cmd;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    w = bus_tick(t);
    if (w.done || !w.busy) begin
      if (exp_err != UNCHECKED) w.ack_error = exp_err[0];
      if (exp_rd != UNCHECKED) w.rd_data = exp_rd[7:0];
    end
    bus_words_due.push_back(w);
    ticks_sent++;
  endtask

  task automatic run_idle(int n, int exp_err, int exp_rd);
    tick_t t;
    repeat (n) begin
      t.start_req = 1'b0;
      t.cmd = 1'($urandom_range(1));
      t.reg_addr = 8'($urandom);
      t.wr_data = 8'($urandom);
      t.sda_in = 1'($urandom_range(1));
      send_tick(t, exp_err, exp_rd);
    end
  endtask

  // One whole transaction, from the request tick until the sequencer is idle.
  task automatic run_xfer(logic cmd, logic [7:0] ra, logic [7:0] wd, int nack_at,
                          logic [7:0] slave_byte, bit rough, int exp_err, int exp_rd);
    tick_t t;
    t.start_req = 1'b1;
    t.cmd = cmd;
    t.reg_addr = ra;
    t.wr_data = wd;
    t.sda_in = 1'($urandom_range(1));
    xfers++;
    reads += cmd;
    send_tick(t, exp_err, exp_rd);
    while (ph != PH_IDLE) begin
      t.start_req = 1'b0;
      // Requests while busy must be ignored by the block.
      if (rough) begin
        t.start_req = ($urandom_range(3) == 0);
        t.cmd = 1'($urandom_range(1));
        t.reg_addr = 8'($urandom);
        t.wr_data = 8'($urandom);
      end
      t.sda_in = line_level(nack_at, slave_byte, rough);
      send_tick(t, exp_err, exp_rd);
    end
  endtask

  // Register writes happen only with the sequencer idle and every result word
  // drained. The model's state is idle here because transactions always run
  // to completion before this is called.
  task automatic set_regs(logic [6:0] dev, logic [7:0] tmo, logic [7:0] plen);
    in_tvalid <= 1'b0;
    while (bus_words_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_DEV_ADDR;
    cfg_wdata <= {1'b0, dev};
    @(posedge clk);
    cfg_addr <= CFG_ACK_TIMEOUT;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_addr <= CFG_PHASE_TICKS;
    cfg_wdata <= plen;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_dev = dev;
    m_tmo = tmo;
    m_plen = plen;
  endtask

  task automatic note_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // The result side stalls at random, with stretches where it never stalls.
  always @(posedge clk) begin
    if ($urandom_range(299) == 0) out_calm <= !out_calm;
    if (out_stall > 0) begin
      out_tready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_tready <= 1'b1;
      out_stall <= out_calm ? 0 : idle_len();
    end
  end

  // Each result word taken is compared with the oldest queued one.
  always @(posedge clk) begin
    bus_word_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (bus_words_due.size() == 0) begin
        $error("result word %0h arrived with nothing expected", out_tdata);
        mismatches++;
      end else begin
        e = bus_words_due.pop_front();
        note_field("scl", e.scl, out_tdata[0]);
        note_field("sda_out", e.sda_out, out_tdata[1]);
        note_field("sda_drive", e.sda_drive, out_tdata[2]);
        note_field("busy_res", e.busy, out_tdata[3]);
        note_field("done_res", e.done, out_tdata[4]);
        note_field("rd_data", e.rd_data, out_tdata[12:5]);
        note_field("ack_error", e.ack_error, out_tdata[13]);
      end
    end
  end

  // Directed rows. The first two run on the reset defaults of the registers;
  // the rest walk the address and timing extremes, each acknowledge abort for
  // writes and reads, a long acknowledge timeout, and a zero timeout and phase
  // length, which act as one.
  // Read-back values and error flags are typed in where they are plain.
  plan_row_t plan [18] = '{
    // xfer idle dev    tmo      plen     cmd   reg     data
    //      nack     slave  rough err        rd
    '{0, 6, 7'd40,  8'd250, 8'd8,   1'b0, 8'h00, 8'h00, ALL_ACK, 8'h00, 0, 0, 8'h00},
    '{1, 0, 7'd40,  8'd250, 8'd8,   1'b0, 8'h00, 8'hFF, ALL_ACK, 8'h00, 0, 0, 8'h00},
    '{1, 0, 7'd40,  8'd250, 8'd1,   1'b1, 8'hFF, 8'h00, ALL_ACK, 8'hA5, 0, 0, 8'hA5},
    '{1, 0, 7'd0,   8'd1,   8'd1,   1'b0, 8'hFF, 8'h00, ALL_ACK, 8'h00, 0, 0, 8'hA5},
    '{1, 0, 7'd127, 8'd1,   8'd1,   1'b1, 8'h00, 8'hFF, ALL_ACK, 8'hFF, 0, 0, 8'hFF},
    '{1, 0, 7'd127, 8'd1,   8'd1,   1'b1, 8'h3C, 8'h00, ALL_ACK, 8'h00, 0, 0, 8'h00},
    '{1, 0, 7'd127, 8'd1,   8'd1,   1'b0, 8'h12, 8'h34, 0,       8'h00, 0, 1, 8'h00},
    '{1, 0, 7'd127, 8'd1,   8'd1,   1'b0, 8'h56, 8'h78, 1,       8'h00, 0, 1, 8'h00},
    '{1, 0, 7'd127, 8'd1,   8'd1,   1'b0, 8'h9A, 8'hBC, 2,       8'h00, 0, 1, 8'h00},
    '{1, 0, 7'd127, 8'd1,   8'd1,   1'b1, 8'hDE, 8'h00, 0,       8'hFF, 0, 1, 8'h00},
    '{1, 0, 7'd127, 8'd1,   8'd1,   1'b1, 8'hF0, 8'h00, 1,       8'hFF, 0, 1, 8'h00},
    '{1, 0, 7'd127, 8'd1,   8'd1,   1'b1, 8'h0F, 8'h00, 2,       8'hFF, 0, 1, 8'h00},
    '{0, 3, 7'd127, 8'd1,   8'd1,   1'b0, 8'h00, 8'h00, ALL_ACK, 8'h00, 0, 1, 8'h00},
    '{1, 0, 7'd85,  8'd255, 8'd1,   1'b0, 8'h55, 8'hAA, 0,       8'h00, 0, 1, 8'h00},
    '{1, 0, 7'd85,  8'd255, 8'd1,   1'b0, 8'hAA, 8'h55, ALL_ACK, 8'h00, 0, 0, 8'h00},
    '{1, 0, 7'd85,  8'd3,   8'd2,   1'b1, 8'h81, 8'h7E, ALL_ACK, 8'h5A, 1,
      UNCHECKED, UNCHECKED},
    '{1, 0, 7'd42,  8'd0,   8'd0,   1'b0, 8'hC3, 8'h3C, 0,       8'h00, 0, 1, UNCHECKED},
    '{1, 0, 7'd40,  8'd1,   8'd1,   1'b1, 8'h66, 8'h99, ALL_ACK, 8'h81, 0, 0, 8'h81}
  };

  initial begin
    int first;
    int drain;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].dev != m_dev || plan[i].tmo != m_tmo || plan[i].plen != m_plen) begin
        set_regs(plan[i].dev, plan[i].tmo, plan[i].plen);
      end
      if (plan[i].is_xfer) begin
        run_xfer(plan[i].cmd, plan[i].ra, plan[i].wd, plan[i].nack_at,
                 plan[i].slave_byte, plan[i].rough, plan[i].exp_err, plan[i].exp_rd);
      end else begin
        run_idle(plan[i].n_idle, plan[i].exp_err, plan[i].exp_rd);
      end
    end

    // Random part: several register settings, short phases so that many
    // transactions fit. Most transactions are fully acknowledged; the rest
    // abort at a random byte. Rough ones add late acknowledges and noise.
    for (int s = 0; s < 4; s++) begin
      case (s)
        0: set_regs(7'($urandom_range(127)), 8'd4, 8'($urandom_range(2, 1)));
        1: set_regs(7'($urandom_range(127)), 8'd1, 8'd1);
        2: set_regs(7'($urandom_range(127)), 8'($urandom_range(20, 2)),
                    8'($urandom_range(3, 1)));
        default: set_regs(7'($urandom_range(127)), 8'd255, 8'($urandom_range(2, 1)));
      endcase
      first = ticks_sent;
      while (ticks_sent - first < TICKS_PER_SETTING) begin
        if ($urandom_range(3) == 0) begin
          run_idle($urandom_range(4, 1), UNCHECKED, UNCHECKED);
        end else begin
          run_xfer(1'($urandom_range(1)), 8'($urandom), 8'($urandom),
                   ($urandom_range(9) < 7) ? ALL_ACK : $urandom_range(2),
                   8'($urandom), 1'($urandom_range(1)), UNCHECKED, UNCHECKED);
        end
      end
    end

    in_tvalid <= 1'b0;
    drain = 0;
    while (bus_words_due.size() != 0 && drain < 10000) begin
      @(posedge clk);
      drain++;
    end
    if (bus_words_due.size() != 0) begin
      $error("%0d result words never arrived", bus_words_due.size());
      mismatches++;
    end
    repeat (4) @(posedge clk);

    $display("Ran %0d bus ticks: %0d transactions, %0d of them reads.", ticks_sent, xfers,
             reads);
    $display("%0d transactions aborted on a missing acknowledge; %0d mismatches.", aborts,
             mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #60000000;
    $display("status: fail");
    $finish;
  end

endmodule
